>>> design/m3i_pkg.sv
// Package for the 3x3 fixed-point matrix inverse.
// Holds default word/fraction widths, the cofactor operand table and a shared flag type.
// No dependencies.
package m3i_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned WordBits = 32;

  // Operand pairs of the eighteen products, two per cofactor (first minus second).
  // Elements are numbered row-major from zero.
  localparam int unsigned CofOpA [18] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2,
                                          2, 0, 3, 4, 1, 0, 0, 1};
  localparam int unsigned CofOpB [18] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6,
                                          3, 5, 7, 6, 6, 7, 4, 3};

  // Determinant flags that travel alongside the quotient pipeline.
  typedef struct packed {
    logic singular;
    logic det_neg;
  } det_flags_t;

endpackage

>>> design/m3i_if.sv
// Handshake interfaces for the matrix input channel and the inverse output channel.
// Depends on m3i_pkg for default widths.
interface m3i_in_if #(
  parameter int unsigned WORD_BITS = m3i_pkg::WordBits
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] m11, m12, m13, m21, m22, m23, m31, m32, m33;

  modport source (output valid, m11, m12, m13, m21, m22, m23, m31, m32, m33, input ready);
  modport sink   (input valid, m11, m12, m13, m21, m22, m23, m31, m32, m33, output ready);
endinterface

interface m3i_out_if #(
  parameter int unsigned WORD_BITS = m3i_pkg::WordBits
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] r11, r12, r13, r21, r22, r23, r31, r32, r33;
  logic                        invertible;
  logic signed [WORD_BITS-1:0] det_out;
  logic                        saturated;

  modport source (output valid, r11, r12, r13, r21, r22, r23, r31, r32, r33,
                  invertible, det_out, saturated, input ready);
  modport sink   (input valid, r11, r12, r13, r21, r22, r23, r31, r32, r33,
                  invertible, det_out, saturated, output ready);
endinterface

>>> design/matrix3x3_inverse.sv
// Inverse of one signed fixed-point 3x3 matrix per beat, as adjugate over determinant.
// Pipeline: cofactor unit, determinant unit, divider (an overflow check, then one
// quotient bit per stage) and output register.
// Throughput: one matrix per cycle; the whole pipeline holds while the output beat waits.
// Reset clears the valid bits only; payload registers are not reset.
module matrix3x3_inverse #(
  parameter int unsigned FRAC_BITS = m3i_pkg::FracBits,
  parameter int unsigned WORD_BITS = m3i_pkg::WordBits
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  m3i_in_if.sink       mat_i,
  m3i_out_if.source    inv_o
);
  // Internal widths: cofactor, determinant, rounded determinant, dividend, divisor.
  localparam int unsigned W    = WORD_BITS;
  localparam int unsigned CW   = 2 * W + 1;
  localparam int unsigned DW   = 3 * W + 3;
  localparam int unsigned AW   = (DW > 2 * FRAC_BITS) ? DW + 1 : 2 * FRAC_BITS + 1;
  localparam int unsigned NW   = ((CW + 2 * FRAC_BITS + 1 > DW) ?
                                  CW + 2 * FRAC_BITS + 1 : DW) + 1;
  localparam int unsigned DENW = DW + 1;
  localparam int unsigned DIVL = W + 1;
  localparam int unsigned PIPE = 5 + DIVL;

  // Global pipeline advance: move whenever the output register is free or drained.
  logic en;
  logic out_vld_q;
  logic [PIPE-1:0] vld_q;

  assign en          = !out_vld_q || inv_o.ready;
  assign mat_i.ready = en;

  // Valid bits travel with the data through every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[PIPE-2:0], mat_i.valid};
      out_vld_q <= vld_q[PIPE-1];
    end
  end

  logic signed [W-1:0] elem [9];
  assign elem = '{mat_i.m11, mat_i.m12, mat_i.m13,
                  mat_i.m21, mat_i.m22, mat_i.m23,
                  mat_i.m31, mat_i.m32, mat_i.m33};

  // Cofactors and first-row elements.
  logic signed [CW-1:0] cof [9];
  logic signed [W-1:0]  row [3];

  m3i_cofactor #(.WORD_BITS(W)) u_cof (
    .clk_i  (clk_i),
    .en_i   (en),
    .elem_i (elem),
    .cof_o  (cof),
    .row_o  (row)
  );

  // Determinant, dividends and divisor.
  logic [NW-1:0]       num [9];
  logic                neg [9];
  logic [DENW-1:0]     den;
  logic [AW-1:0]       dq;
  m3i_pkg::det_flags_t flags;

  m3i_det #(
    .WORD_BITS (W),
    .FRAC_BITS (FRAC_BITS),
    .DW        (DW),
    .AW        (AW),
    .NW        (NW),
    .DENW      (DENW)
  ) u_det (
    .clk_i   (clk_i),
    .en_i    (en),
    .cof_i   (cof),
    .row_i   (row),
    .num_o   (num),
    .neg_o   (neg),
    .den_o   (den),
    .dq_o    (dq),
    .flags_o (flags)
  );

  // Nine parallel dividers; the sign of each quotient rides along as a tag.
  logic [W-1:0] quo   [9];
  logic         ovf   [9];
  logic         qneg  [9];

  for (genvar k = 0; k < 9; k++) begin : g_div
    m3i_divider #(.NW(NW), .DENW(DENW), .QW(W)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num[k]),
      .den_i (den),
      .tag_i (neg[k]),
      .quo_o (quo[k]),
      .ovf_o (ovf[k]),
      .tag_o (qneg[k])
    );
  end

  // Delay the determinant side data to line up with the quotients.
  logic [AW-1:0]       dq_dly_q    [DIVL];
  m3i_pkg::det_flags_t flags_dly_q [DIVL];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dq_dly_q[0]    <= dq;
      flags_dly_q[0] <= flags;
      for (int s = 1; s < DIVL; s++) begin
        dq_dly_q[s]    <= dq_dly_q[s-1];
        flags_dly_q[s] <= flags_dly_q[s-1];
      end
    end
  end

  // Saturating conversion: clip the magnitude against the signed limit, then apply sign.
  logic [AW-1:0] lim_pos, lim_neg;
  assign lim_pos = (AW'(1) << (W - 1)) - AW'(1);
  assign lim_neg = AW'(1) << (W - 1);

  logic [W-1:0] res   [9];
  logic         rclip [9];

  for (genvar k = 0; k < 9; k++) begin : g_clip
    logic [AW-1:0] mag;
    assign mag      = AW'(quo[k]);
    assign rclip[k] = ovf[k] || (mag > (qneg[k] ? lim_neg : lim_pos));
    assign res[k]   = rclip[k] ? (qneg[k] ? W'(lim_neg) : W'(lim_pos))
                               : (qneg[k] ? W'(-mag) : W'(mag));
  end

  m3i_pkg::det_flags_t fl;
  logic [AW-1:0]       dqd;
  logic                dclip;
  logic [W-1:0]        det_val;
  assign fl      = flags_dly_q[DIVL-1];
  assign dqd     = dq_dly_q[DIVL-1];
  assign dclip   = dqd > (fl.det_neg ? lim_neg : lim_pos);
  assign det_val = dclip ? (fl.det_neg ? W'(lim_neg) : W'(lim_pos))
                         : (fl.det_neg ? W'(-dqd) : W'(dqd));

  // Identity for a singular matrix; 1.0 clips when the fraction fills the word.
  localparam bit OneClips = (FRAC_BITS >= W - 1);
  logic [W-1:0] one_val;
  assign one_val = OneClips ? W'(lim_pos) : (W'(1) << FRAC_BITS);

  logic [W-1:0] r_d [9];
  logic         sat_d;
  logic         any_clip;

  always_comb begin
    any_clip = dclip;
    for (int k = 0; k < 9; k++) begin
      any_clip = any_clip | rclip[k];
    end
    for (int k = 0; k < 9; k++) begin
      r_d[k] = fl.singular ? ((k % 4 == 0) ? one_val : '0) : res[k];
    end
    sat_d = fl.singular ? OneClips : any_clip;
  end

  // Output register: hold while the beat waits.
  logic [W-1:0] r_q [9];
  logic [W-1:0] det_q;
  logic         inv_q;
  logic         sat_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q   <= r_d;
      det_q <= fl.singular ? '0 : det_val;
      inv_q <= !fl.singular;
      sat_q <= sat_d;
    end
  end

  assign inv_o.valid      = out_vld_q;
  assign inv_o.r11        = r_q[0];
  assign inv_o.r12        = r_q[1];
  assign inv_o.r13        = r_q[2];
  assign inv_o.r21        = r_q[3];
  assign inv_o.r22        = r_q[4];
  assign inv_o.r23        = r_q[5];
  assign inv_o.r31        = r_q[6];
  assign inv_o.r32        = r_q[7];
  assign inv_o.r33        = r_q[8];
  assign inv_o.invertible = inv_q;
  assign inv_o.det_out    = det_q;
  assign inv_o.saturated  = sat_q;
endmodule

>>> design/m3i_cofactor.sv
// Two-stage cofactor unit: eighteen registered products, then nine differences.
// Depends on m3i_pkg for the operand table.
module m3i_cofactor #(
  parameter int unsigned WORD_BITS = m3i_pkg::WordBits
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [WORD_BITS-1:0]   elem_i [9],
  output logic signed [2*WORD_BITS:0]   cof_o  [9],
  output logic signed [WORD_BITS-1:0]   row_o  [3]
);
  localparam int unsigned PW = 2 * WORD_BITS;
  localparam int unsigned CW = 2 * WORD_BITS + 1;

  logic signed [PW-1:0]        prod_q [18];
  logic signed [WORD_BITS-1:0] row1_q [3];
  logic signed [CW-1:0]        cof_q  [9];
  logic signed [WORD_BITS-1:0] row2_q [3];

  for (genvar k = 0; k < 18; k++) begin : g_prod
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        prod_q[k] <= elem_i[m3i_pkg::CofOpA[k]] * elem_i[m3i_pkg::CofOpB[k]];
      end
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_cof
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cof_q[k] <= CW'(prod_q[2*k]) - CW'(prod_q[2*k+1]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      row1_q <= elem_i[0:2];
      row2_q <= row1_q;
    end
  end

  assign cof_o = cof_q;
  assign row_o = row2_q;
endmodule

>>> design/m3i_det.sv
// Three-stage determinant unit: split partial products, sum, then magnitudes,
// dividends, divisor and rounded determinant. Depends on m3i_pkg.
module m3i_det #(
  parameter int unsigned WORD_BITS = m3i_pkg::WordBits,
  parameter int unsigned FRAC_BITS = m3i_pkg::FracBits,
  parameter int unsigned DW        = 3 * WORD_BITS + 3,
  parameter int unsigned AW        = DW + 1,
  parameter int unsigned NW        = DW + 1,
  parameter int unsigned DENW      = DW + 1
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [2*WORD_BITS:0]   cof_i [9],
  input  logic signed [WORD_BITS-1:0]   row_i [3],
  output logic [NW-1:0]                 num_o [9],
  output logic                          neg_o [9],
  output logic [DENW-1:0]               den_o,
  output logic [AW-1:0]                 dq_o,
  output m3i_pkg::det_flags_t           flags_o
);
  localparam int unsigned CW = 2 * WORD_BITS + 1;
  localparam int unsigned LW = WORD_BITS + 1;

  logic signed [2*WORD_BITS+1:0] plo_q [3];
  logic signed [2*WORD_BITS-1:0] phi_q [3];
  logic signed [CW-1:0]          cofa_q [9];
  logic signed [CW-1:0]          cofb_q [9];
  logic signed [DW-1:0]          det_q;
  logic signed [DW-1:0]          det_d;
  logic [DW-1:0]                 dmag;
  logic [NW-1:0]                 num_q [9];
  logic                          neg_q [9];
  logic [DENW-1:0]               den_q;
  logic [AW-1:0]                 dq_q;
  m3i_pkg::det_flags_t           flags_q;

  // Stage A: split each cofactor into a low unsigned and a high signed part.
  for (genvar j = 0; j < 3; j++) begin : g_part
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        plo_q[j] <= row_i[j] * $signed({1'b0, cof_i[3*j][LW-1:0]});
        phi_q[j] <= row_i[j] * $signed(cof_i[3*j][CW-1:LW]);
      end
    end
  end

  // Stage B: recombine and sum.
  always_comb begin
    det_d = '0;
    for (int j = 0; j < 3; j++) begin
      det_d = det_d + (DW'(phi_q[j]) <<< LW) + DW'(plo_q[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cofa_q <= cof_i;
      cofb_q <= cofa_q;
      det_q  <= det_d;
    end
  end

  // Stage C: magnitudes and rounding terms.
  assign dmag = det_q[DW-1] ? DW'(-det_q) : DW'(det_q);

  for (genvar k = 0; k < 9; k++) begin : g_num
    logic [CW-1:0] cmag;
    assign cmag = cofb_q[k][CW-1] ? CW'(-cofb_q[k]) : CW'(cofb_q[k]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k] <= (NW'(cmag) << (2 * FRAC_BITS + 1)) + NW'(dmag);
        neg_q[k] <= cofb_q[k][CW-1] ^ det_q[DW-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q            <= DENW'(dmag) << 1;
      dq_q             <= (AW'(dmag) + (AW'(1) << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
      flags_q.singular <= (det_q == '0);
      flags_q.det_neg  <= det_q[DW-1];
    end
  end

  assign num_o   = num_q;
  assign neg_o   = neg_q;
  assign den_o   = den_q;
  assign dq_o    = dq_q;
  assign flags_o = flags_q;
endmodule

>>> design/m3i_divider.sv
// Pipelined restoring divider: one overflow check stage, then one quotient bit per stage.
// Standalone; widths come from the instantiating level.
module m3i_divider #(
  parameter int unsigned NW   = 100,
  parameter int unsigned DENW = 100,
  parameter int unsigned QW   = 32
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NW-1:0]   num_i,
  input  logic [DENW-1:0] den_i,
  input  logic            tag_i,
  output logic [QW-1:0]   quo_o,
  output logic            ovf_o,
  output logic            tag_o
);
  localparam int unsigned RW = (NW > DENW + QW) ? NW : DENW + QW;

  logic [RW-1:0]   rem_q [QW+1];
  logic [QW-1:0]   quo_q [QW+1];
  logic [DENW-1:0] den_q [QW+1];
  logic            ovf_q [QW+1];
  logic            tag_q [QW+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= RW'(num_i);
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      ovf_q[0] <= RW'(num_i) >= (RW'(den_i) << QW);
      tag_q[0] <= tag_i;
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_step
    localparam int unsigned B = QW - s;
    logic [RW-1:0] dsh;
    logic          ge;
    logic [QW-1:0] quo_d;

    assign dsh = RW'(den_q[s-1]) << B;
    assign ge  = rem_q[s-1] >= dsh;

    always_comb begin
      quo_d    = quo_q[s-1];
      quo_d[B] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? (rem_q[s-1] - dsh) : rem_q[s-1];
        quo_q[s] <= quo_d;
        den_q[s] <= den_q[s-1];
        ovf_q[s] <= ovf_q[s-1];
        tag_q[s] <= tag_q[s-1];
      end
    end
  end

  assign quo_o = quo_q[QW];
  assign ovf_o = ovf_q[QW];
  assign tag_o = tag_q[QW];
endmodule
